// File: hw/rtl/npc_pkg.sv
package npc_pkg;

  // Request action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Field widths.
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 3 * CH_W;
  localparam int DIST_W    = 10;
  localparam int IDX_OUT_W = 8;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int CFG_W      = 9;

  // Register indexes, taken from the word address bit of paddr.
  localparam logic REG_COLOR_COUNT = 1'b0;

  localparam logic [CFG_W-1:0] COLOR_COUNT_RESET = 9'd256;

  // Control from the sequencer to the distance unit.
  typedef struct packed {
    logic start;
    logic sample_valid;
  } scan_ctrl_t;

  // Status from the distance unit back to the sequencer.
  typedef struct packed {
    logic                 busy;
    logic [IDX_OUT_W-1:0] win_index;
  } scan_stat_t;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: hw/rtl/npc_ram.sv
module npc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/npc_scan.sv
module npc_scan
  import npc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  scan_ctrl_t         ctrl,
  input  logic [COLOR_W-1:0] sample,
  input  logic [CH_W-1:0]    q_red,
  input  logic [CH_W-1:0]    q_green,
  input  logic [CH_W-1:0]    q_blue,
  output scan_stat_t         stat
);

  logic [DIST_W-1:0]    cur_dist;
  logic                 dist_valid;
  logic [DIST_W-1:0]    best_dist;
  logic [IDX_OUT_W-1:0] win_index;
  logic [IDX_OUT_W-1:0] cmp_idx;
  logic                 found;
  logic [DIST_W-1:0]    dist_sum;

  assign dist_sum = DIST_W'(abs_diff(sample[CH_W-1:0], q_red))
                  + DIST_W'(abs_diff(sample[2*CH_W-1:CH_W], q_green))
                  + DIST_W'(abs_diff(sample[3*CH_W-1:2*CH_W], q_blue));

  // Distance stage carries no reset: dist_valid qualifies it.
  always_ff @(posedge clk) begin
    cur_dist <= dist_sum;
  end

  // Compare stage. Only a strictly smaller distance replaces the best,
  // so ties keep the lower index.
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
      found      <= 1'b0;
      win_index  <= '0;
      cmp_idx    <= '0;
    end else begin
      dist_valid <= ctrl.sample_valid;
      if (ctrl.start) begin
        found      <= 1'b0;
        win_index  <= '0;
        cmp_idx    <= '0;
      end else if (dist_valid) begin
        cmp_idx <= cmp_idx + 1'b1;
        if (!found || cur_dist < best_dist) begin
          found      <= 1'b1;
          win_index  <= cmp_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dist_valid && (!found || cur_dist < best_dist)) begin
      best_dist <= cur_dist;
    end
  end

  assign stat.busy      = dist_valid;
  assign stat.win_index = win_index;

endmodule

// File: hw/rtl/nearest_palette_color_top.sv
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------------
// request   | in_valid / in_ready          | action, entry_index, entry_color, red,
//           |                              | green, blue
// result    | out_valid / out_ready        | nearest_index (queries only)
// config    | psel, penable, pwrite, pready| paddr, pwdata, prdata (color_count at 0)
//
// A query reads the palette memory one entry per cycle through its single read
// port, followed by the distance and compare stages and the hand-off to the output.
// After reset the palette memory is cleared in a pass over its min(PALETTE_ENTRIES,
// 256) entries, during which no request is accepted.
// A finished result waits in the output register; write requests are accepted
// meanwhile, and a following query stalls only at its end until that slot frees.
module nearest_palette_color_top
  import npc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [7:0]            entry_index,
  input  logic [COLOR_W-1:0]    entry_color,
  input  logic [CH_W-1:0]       red,
  input  logic [CH_W-1:0]       green,
  input  logic [CH_W-1:0]       blue,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_OUT_W-1:0]  nearest_index,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Write requests carry an 8-bit index, so no more than 256 entries can ever
  // hold a color. Entries above that always read as black and need no storage.
  localparam int MEM_DEPTH = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  // The scan counter must hold the entry count itself.
  localparam int CNT_W     = $clog2(PALETTE_ENTRIES + 1);
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   limit;
  logic [CFG_W-1:0]   color_count;
  logic [CH_W-1:0]    q_red, q_green, q_blue;
  logic               rd_valid;
  logic               rd_beyond;

  logic               in_acc;
  logic               query_acc;
  logic               write_acc;
  logic               write_in_range;
  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   count_sat;
  logic [CNT_W-1:0]   limit_req;
  logic               scan_last;
  logic               scan_beyond;
  logic               out_load;
  logic               cfg_we;

  logic               ram_we;
  logic [MEM_AW-1:0]  ram_waddr;
  logic [COLOR_W-1:0] ram_wdata;
  logic               ram_re;
  logic [COLOR_W-1:0] ram_rdata;
  logic [COLOR_W-1:0] sample;

  scan_ctrl_t         ctrl;
  scan_stat_t         stat;

  // Request acceptance: only in idle, independent of the output register.
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign query_acc = in_acc && (action == ACT_QUERY);

  // Writes beyond the palette are dropped.
  assign write_in_range = CMP_W'(entry_index) < CMP_W'(PALETTE_ENTRIES);
  assign write_acc      = in_acc && (action == ACT_WRITE) && write_in_range;

  // A count above the palette size searches the whole palette.
  assign count_ext = CMP_W'(color_count);
  assign count_sat = (count_ext > CMP_W'(PALETTE_ENTRIES)) ? CMP_W'(PALETTE_ENTRIES)
                                                           : count_ext;
  assign limit_req = count_sat[CNT_W-1:0];

  assign scan_last   = (cnt == limit - CNT_W'(1));
  assign scan_beyond = (cnt >= CNT_W'(MEM_DEPTH));

  // The result is loaded once the search has settled and the slot is free.
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_CLEAR: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(MEM_DEPTH - 1)) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end
      end
      S_IDLE: begin
        cnt_next = '0;
        if (query_acc) begin
          // A zero count skips the search and answers index zero.
          state_next = (limit_req == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_next = cnt + CNT_W'(1);
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_valid && !stat.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      rd_valid <= ram_re;
    end
  end

  // Query operands and the read qualifier for entries past the memory.
  always_ff @(posedge clk) begin
    rd_beyond <= scan_beyond;
    if (query_acc) begin
      q_red   <= red;
      q_green <= green;
      q_blue  <= blue;
      limit   <= limit_req;
    end
  end

  // Palette memory: the clearing pass and write requests share the write
  // port, which never conflicts with a scan since requests wait during one.
  assign ram_we    = (state == S_CLEAR) || write_acc;
  assign ram_waddr = (state == S_CLEAR) ? cnt[MEM_AW-1:0] : entry_index[MEM_AW-1:0];
  assign ram_wdata = (state == S_CLEAR) ? '0 : entry_color;
  assign ram_re    = (state == S_SCAN);

  npc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MEM_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt[MEM_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign sample = rd_beyond ? '0 : ram_rdata;

  assign ctrl.start        = query_acc;
  assign ctrl.sample_valid = rd_valid;

  npc_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .sample  (sample),
    .q_red   (q_red),
    .q_green (q_green),
    .q_blue  (q_blue),
    .stat    (stat)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      nearest_index <= stat.win_index;
    end
  end

  // Configuration port: the word address bit selects the register.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_COLOR_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count <= COLOR_COUNT_RESET;
    end else if (cfg_we) begin
      color_count <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[APB_ADDR_W-1] == REG_COLOR_COUNT) ? APB_DATA_W'(color_count) : '0;

endmodule

// File: tb/nearest_palette_color_checker.sv
`timescale 1ns / 1ps

module nearest_palette_color_checker
  import npc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  action,
  input  logic [7:0]            entry_index,
  input  logic [COLOR_W-1:0]    entry_color,
  input  logic [CH_W-1:0]       red,
  input  logic [CH_W-1:0]       green,
  input  logic [CH_W-1:0]       blue,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [IDX_OUT_W-1:0]  nearest_index,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked
);

  localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = {REG_COLOR_COUNT, 2'b00};

  logic [COLOR_W-1:0]   palette_copy [PALETTE_ENTRIES];
  logic [CFG_W-1:0]     search_count;
  logic [IDX_OUT_W-1:0] expected_index_q [$];
  int                   mismatches = 0;
  int                   checked = 0;

  function automatic logic [DIST_W-1:0] channel_gap(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b);
    return (a > b) ? DIST_W'(a - b) : DIST_W'(b - a);
  endfunction

  // Full scan of the leading entries; the first entry always seeds the best match
  // and only a strictly smaller distance replaces it, so ties keep the lowest index.
  function automatic logic [IDX_OUT_W-1:0] nearest_entry(input logic [CH_W-1:0] r,
                                                         input logic [CH_W-1:0] g,
                                                         input logic [CH_W-1:0] b);
    int                limit;
    int                best;
    logic [DIST_W-1:0] best_dist;
    logic [DIST_W-1:0] gap_sum;
    limit = (int'(search_count) > PALETTE_ENTRIES) ? PALETTE_ENTRIES : int'(search_count);
    best = 0;
    best_dist = '0;
    for (int i = 0; i < limit; i++) begin
      gap_sum = channel_gap(palette_copy[i][7:0], r) + channel_gap(palette_copy[i][15:8], g)
              + channel_gap(palette_copy[i][23:16], b);
      if (i == 0 || gap_sum < best_dist) begin
        best = i;
        best_dist = gap_sum;
      end
    end
    return best[IDX_OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) palette_copy[i] = '0;
      search_count = COLOR_COUNT_RESET;
      expected_index_q.delete();
    end else begin
      if (psel && penable && pready && paddr == COUNT_ADDR) begin
        if (pwrite) begin
          search_count = pwdata[CFG_W-1:0];
        end else if (prdata != APB_DATA_W'(search_count)) begin
          report_mismatch($sformatf("color_count read back %0d, expected %0d",
                                    prdata, search_count));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_index_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no query outstanding", nearest_index));
        end else begin
          if (nearest_index !== expected_index_q[0]) begin
            report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                      nearest_index, expected_index_q[0]));
          end
          void'(expected_index_q.pop_front());
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (action == ACT_WRITE) begin
          if (int'(entry_index) < PALETTE_ENTRIES) palette_copy[entry_index] = entry_color;
        end else begin
          expected_index_q.push_back(nearest_entry(red, green, blue));
        end
      end
    end
    fail_count <= mismatches;
    pending <= expected_index_q.size();
    results_checked <= checked;
  end

endmodule

// File: tb/nearest_palette_color_top_test.sv
`timescale 1ns / 1ps

module nearest_palette_color_top_test;
  import npc_pkg::*;

  localparam int PALETTE_ENTRIES = 256;
  // A query scans up to 256 entries plus the distance and compare stages; the drain
  // wait covers a query that may still be in flight after the last result.
  localparam int DRAIN_CYCLES    = 300;
  // Cycles without any accepted request or result before the run is abandoned.
  localparam int STALL_LIMIT     = 20000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES     = 1500;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = {REG_COLOR_COUNT, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  action;
  logic [7:0]            entry_index;
  logic [COLOR_W-1:0]    entry_color;
  logic [CH_W-1:0]       red;
  logic [CH_W-1:0]       green;
  logic [CH_W-1:0]       blue;
  logic                  out_valid;
  logic                  out_ready;
  logic [IDX_OUT_W-1:0]  nearest_index;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int results_checked;

  // Idle rates in percent per cycle for the request sender and the result receiver.
  int send_idle_pct = 25;
  int recv_idle_pct = 77;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_pending = 1'b0;
  int quiet_cycles = 0;

  // Colors the stimulus has written, used to aim queries near real entries.
  logic [COLOR_W-1:0] written_colors [PALETTE_ENTRIES];
  int active_count = 256;
  int write_requests = 0;
  int query_requests = 0;
  int sizes_used = 0;

  always #5 clk = ~clk;

  nearest_palette_color_top #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .entry_index  (entry_index),
    .entry_color  (entry_color),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .nearest_index(nearest_index),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  nearest_palette_color_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .entry_index    (entry_index),
    .entry_color    (entry_color),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .nearest_index  (nearest_index),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked)
  );

  // The receiver makes one ready decision per clock edge outside a hold-off. When
  // a hold-off is requested it drops ready and counts the stretch itself, while the
  // sender keeps offering requests until the block fills up and stalls its input.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_ready <= 1'b0;
        hold_pending = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // The watchdog ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request or result accepted for %0d cycles", STALL_LIMIT);
      $display("nearest_palette_color_top: mismatch");
      $finish;
    end
  end

  // Offers one request after a random number of idle cycles and returns at the
  // edge at which it was accepted, with valid still high.
  task automatic send_request(input logic act, input logic [7:0] idx,
                              input logic [COLOR_W-1:0] col, input logic [CH_W-1:0] r,
                              input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    entry_index <= idx;
    entry_color <= col;
    red         <= r;
    green       <= g;
    blue        <= b;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_WRITE) begin
      written_colors[idx] = col;
      write_requests++;
    end else begin
      query_requests++;
    end
  endtask

  // Lets every outstanding query finish, then waits out a scan that could still
  // be running, so that the block is idle for a register write.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes color_count and reads it straight back; the checker compares the
  // read data with its own copy of the register.
  task automatic set_color_count(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    active_count = value;
    sizes_used++;
  endtask

  // Most writes land inside the searched range and most queries sit close to
  // a stored entry, so that the compare decides between near neighbors. Extreme
  // colors and copied colors make ties; the rest is plain noise.
  task automatic send_random_request();
    logic               act;
    logic [7:0]         idx;
    logic [COLOR_W-1:0] col;
    logic [COLOR_W-1:0] target;
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
    logic [CH_W-1:0]    jitter;
    int                 roll;
    int                 span;
    roll = $urandom_range(99);
    span = (active_count > PALETTE_ENTRIES) ? PALETTE_ENTRIES : active_count;
    idx  = 8'($urandom);
    col  = COLOR_W'($urandom);
    r    = CH_W'($urandom);
    g    = CH_W'($urandom);
    b    = CH_W'($urandom);
    if (roll < 45) begin
      act = ACT_WRITE;
      if (span > 0 && $urandom_range(9) < 7) idx = 8'($urandom_range(span - 1));
      case ($urandom_range(3))
        0: col = '0;
        1: col = '1;
        2: begin
          jitter = CH_W'($urandom_range(3));
          col = written_colors[8'($urandom_range(PALETTE_ENTRIES - 1))] ^ {16'h0, jitter};
        end
        default: ;
      endcase
    end else begin
      act = ACT_QUERY;
      if (roll < 90) begin
        target = written_colors[(span > 0) ? 8'($urandom_range(span - 1)) : 8'd0];
        jitter = CH_W'($urandom_range(7));
        r = target[7:0] ^ jitter;
        jitter = CH_W'($urandom_range(7));
        g = target[15:8] ^ jitter;
        jitter = CH_W'($urandom_range(7));
        b = target[23:16] ^ jitter;
      end
    end
    send_request(act, idx, col, r, g, b);
  endtask

  initial begin
    int count_value;
    for (int i = 0; i < PALETTE_ENTRIES; i++) written_colors[i] = '0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    action      <= ACT_WRITE;
    entry_index <= '0;
    entry_color <= '0;
    red         <= '0;
    green       <= '0;
    blue        <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset count of 256. An all-black palette makes every
    // entry tie, so the answer is index 0 whatever the query color.
    send_request(ACT_QUERY, 8'hFF, 24'hFFFFFF, 8'h00, 8'h00, 8'h00);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'hFF, 8'hFF, 8'hFF);
    // White at the last index wins a white query; a write ignores its channel fields.
    send_request(ACT_WRITE, 8'hFF, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_WRITE, 8'h00, 24'h000000, 8'hFF, 8'hFF, 8'hFF);
    // The same color at two indexes: the lower one must be reported.
    send_request(ACT_WRITE, 8'h07, 24'h123456, 8'h00, 8'h00, 8'h00);
    send_request(ACT_WRITE, 8'h09, 24'h123456, 8'h00, 8'h00, 8'h00);
    send_request(ACT_QUERY, 8'h09, 24'hFFFFFF, 8'h56, 8'h34, 8'h12);
    // A near miss on a single entry and pure primaries in each channel.
    send_request(ACT_WRITE, 8'h80, 24'h808080, 8'h00, 8'h00, 8'h00);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'h7F, 8'h81, 8'h80);
    send_request(ACT_WRITE, 8'h01, 24'h0000FF, 8'h00, 8'h00, 8'h00);
    send_request(ACT_WRITE, 8'h02, 24'h00FF00, 8'h00, 8'h00, 8'h00);
    send_request(ACT_WRITE, 8'h03, 24'hFF0000, 8'h00, 8'h00, 8'h00);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'hF0, 8'h10, 8'h10);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'h10, 8'hF0, 8'h10);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'h10, 8'h10, 8'hF0);

    // A count of zero searches nothing and answers index 0.
    wait_for_idle();
    set_color_count(0);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_QUERY, 8'hFF, 24'hFFFFFF, 8'h80, 8'h80, 8'h80);
    // A single entry is always the nearest.
    wait_for_idle();
    set_color_count(1);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'hFF, 8'hFF, 8'hFF);
    // Counts above the palette size saturate, so the white entry at 255 is found.
    wait_for_idle();
    set_color_count(511);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_QUERY, 8'h00, 24'h000000, 8'h7E, 8'h80, 8'h82);

    // Random phases. The first three let the receiver idle most, the next three
    // the sender, and the last two run without any idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 77;
      end else if (p < 6) begin
        send_idle_pct = 77;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: count_value = 256;
        1: count_value = 1;
        2: count_value = 2;
        3: count_value = $urandom_range(3, 255);
        4: count_value = 255;
        5: count_value = $urandom_range(257, 511);
        6: count_value = 0;
        default: count_value = $urandom_range(3, 40);
      endcase
      wait_for_idle();
      set_color_count(count_value);
      // One phase starts with the long receiver hold-off.
      if (p == 4) hold_pending = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random_request();
    end

    wait_for_idle();
    $display("Run covered %0d palette writes and %0d nearest-color queries over %0d counts.",
             write_requests, query_requests, sizes_used);
    $display("%0d results compared, %0d failures reported.", results_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("nearest_palette_color_top: match");
    end else begin
      $display("nearest_palette_color_top: mismatch");
    end
    $finish;
  end

endmodule
